// ===== design/ir_pulse_width_capture_defines.svh =====
// assertion macros shared by the capture block
`ifndef IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define IRPWC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ir_pulse_width_capture: check failed");
// condition holds on every enabled clock edge
`define IRPWC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("ir_pulse_width_capture: check failed");
`else
`define IRPWC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define IRPWC_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/irpwc_pkg.sv =====
package irpwc_pkg;

    // input command codes
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_SAMPLE = 3'd1,
        CMD_CHAR   = 3'd2,
        CMD_READ   = 3'd3,
        CMD_ARM    = 3'd4
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEVICE_MODE   = 2'd0,
        CFG_SENSE_SETTING = 2'd1,
        CFG_VIRTUAL_PULSE = 2'd2,
        CFG_TIMEOUT_US    = 2'd3
    } cfg_reg_t;

    localparam int unsigned CFG_INDEX_BITS = 2;

    // offset taken off the gap before a character event
    localparam int unsigned CHAR_OFFSET = 100;

    // timeout after reset, truncated to the timer width
    localparam logic [31:0] TIMEOUT_RESET = 32'd16_000_000;

    // fifo operation requested by one accepted word
    typedef struct packed {
        logic push_one;
        logic push_two;
        logic pop;
        logic clear;
    } fifo_req_t;

endpackage

// ===== design/ir_pulse_width_capture.sv =====
// Infrared pulse/space capture. Commands come in on the input channel one word at a
// time; every accepted word gives exactly one result word, through the stage-one and
// output registers, holding the FIFO word read (if any), the fill level, the sticky
// overflow flag and the present sense. One command is taken per clock while the input
// does not stall. A character event in character mode whose two words both fit in the
// FIFO stalls the input, because both of its words are written through the single
// write port of the word memory. The input also stalls while a finished result waits
// on out_ready and the next result is already behind it. The word memory needs no
// clearing after reset, so the block accepts commands from the first cycle out of reset.
`include "ir_pulse_width_capture_defines.svh"

module ir_pulse_width_capture #(
    parameter int FIFO_DEPTH = 256,
    parameter int TIME_BITS  = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [irpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]                 cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           command,
    input  logic                                 line_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 data_valid,
    output logic [TIME_BITS:0]                   data_word,
    output logic [$clog2(FIFO_DEPTH + 1)-1:0]    fifo_level,
    output logic                                 overflow,
    output logic                                 sense_now
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    irpwc_pkg::fifo_req_t req;
    logic [TIME_BITS:0]   word_a;
    logic [TIME_BITS:0]   word_b;
    logic                 pop_hit;
    logic [TIME_BITS:0]   rdata;
    logic [CW-1:0]        level;
    logic                 fifo_overflow;
    logic                 busy;
    logic                 sense;

    logic                 accept;
    logic                 s1_adv;
    logic                 s1_valid_reg;
    logic                 s1_hit_reg;
    logic                 out_valid_reg;
    logic                 data_valid_reg;
    logic [TIME_BITS:0]   data_word_reg;
    logic [CW-1:0]        fifo_level_reg;
    logic                 overflow_reg;
    logic                 sense_now_reg;

    // handshake: stall while the second word is written or the result path is full
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !busy && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    irpwc_ctrl #(
        .TIME_BITS(TIME_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (accept),
        .command    (command),
        .line_level (line_level),
        .req        (req),
        .word_a     (word_a),
        .word_b     (word_b),
        .sense_now  (sense)
    );

    irpwc_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept),
        .req      (req),
        .word_a   (word_a),
        .word_b   (word_b),
        .pop_hit  (pop_hit),
        .rdata    (rdata),
        .level    (level),
        .overflow (fifo_overflow),
        .busy     (busy)
    );

    // stage one: waits for the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_hit_reg   <= pop_hit && !req.clear;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // output register, status sampled after the word's own update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            data_valid_reg <= s1_hit_reg;
            data_word_reg  <= s1_hit_reg ? rdata : '0;
            fifo_level_reg <= level;
            overflow_reg   <= fifo_overflow;
            sense_now_reg  <= sense;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = data_valid_reg;
    assign data_word  = data_word_reg;
    assign fifo_level = fifo_level_reg;
    assign overflow   = overflow_reg;
    assign sense_now  = sense_now_reg;

    `IRPWC_ASSERT_IMPLY(a_busy_stalls, clk, rst_n, busy, !in_ready)
    `IRPWC_ASSERT_IMPLY(a_empty_read_zero, clk, rst_n, out_valid_reg && !data_valid_reg, data_word_reg == '0)
    `IRPWC_ASSERT_IMPLY(a_s1_blocked, clk, rst_n, s1_valid_reg && !s1_adv, !in_ready)

endmodule

// ===== design/irpwc_ctrl.sv =====
module irpwc_ctrl #(
    parameter int TIME_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [irpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]                 cfg_data,
    input  logic                                 step,
    input  logic [2:0]                           command,
    input  logic                                 line_level,
    output irpwc_pkg::fifo_req_t                 req,
    output logic [TIME_BITS:0]                   word_a,
    output logic [TIME_BITS:0]                   word_b,
    output logic                                 sense_now
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] OFFSET   = TIME_BITS'(irpwc_pkg::CHAR_OFFSET);
    localparam logic [TIME_BITS-1:0] TMO_RST  = TIME_BITS'(irpwc_pkg::TIMEOUT_RESET);

    logic                 device_mode_reg;
    logic [1:0]           sense_setting_reg;
    logic [TIME_BITS-1:0] virtual_pulse_reg;
    logic [TIME_BITS-1:0] timeout_us_reg;

    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 last_level_reg, last_level_next;
    logic                 sense_reg, sense_next;

    logic                 timed_out;
    logic [TIME_BITS-1:0] char_gap;

    assign timed_out = elapsed_reg > timeout_us_reg;
    assign char_gap  = (elapsed_reg > OFFSET) ? (elapsed_reg - OFFSET) : '0;
    assign sense_now = sense_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_mode_reg   <= 1'b1;
            sense_setting_reg <= 2'd2;
            virtual_pulse_reg <= '0;
            timeout_us_reg    <= TMO_RST;
        end
        else if (cfg_write)
        begin
            unique case (irpwc_pkg::cfg_reg_t'(cfg_index))
                irpwc_pkg::CFG_DEVICE_MODE:   device_mode_reg   <= cfg_data[0];
                irpwc_pkg::CFG_SENSE_SETTING: sense_setting_reg <= cfg_data[1:0];
                irpwc_pkg::CFG_VIRTUAL_PULSE: virtual_pulse_reg <= cfg_data;
                irpwc_pkg::CFG_TIMEOUT_US:    timeout_us_reg    <= cfg_data;
            endcase
        end
    end

    // command decode: timer, level tracking and fifo requests
    always_comb
    begin
        req             = '0;
        word_a          = '0;
        word_b          = '0;
        elapsed_next    = elapsed_reg;
        last_level_next = last_level_reg;
        sense_next      = sense_reg;
        if (step)
        begin
            unique case (irpwc_pkg::cmd_t'(command))
                irpwc_pkg::CMD_TICK:
                begin
                    if (elapsed_reg != TIME_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                irpwc_pkg::CMD_SAMPLE:
                begin
                    if (device_mode_reg && (line_level != last_level_reg))
                    begin
                        last_level_next = line_level;
                        // a too long gap means the sense was wrong if it matches
                        if (timed_out && (line_level == sense_reg))
                        begin
                            sense_next = ~sense_reg;
                        end
                        word_a       = {line_level == sense_next,
                                        timed_out ? TIME_MAX : elapsed_reg};
                        req.push_one = 1'b1;
                        elapsed_next = '0;
                    end
                end
                irpwc_pkg::CMD_CHAR:
                begin
                    if (!device_mode_reg)
                    begin
                        word_a       = {1'b0, char_gap};
                        word_b       = {1'b1, virtual_pulse_reg};
                        req.push_one = 1'b1;
                        req.push_two = 1'b1;
                        elapsed_next = '0;
                    end
                end
                irpwc_pkg::CMD_READ:
                begin
                    req.pop = 1'b1;
                end
                irpwc_pkg::CMD_ARM:
                begin
                    req.clear       = 1'b1;
                    elapsed_next    = '0;
                    last_level_next = line_level;
                    sense_next      = sense_setting_reg[1] ? line_level
                                                           : sense_setting_reg[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // timer and level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            last_level_reg <= 1'b0;
            sense_reg      <= 1'b0;
        end
        else
        begin
            elapsed_reg    <= elapsed_next;
            last_level_reg <= last_level_next;
            sense_reg      <= sense_next;
        end
    end

endmodule

// ===== design/irpwc_fifo.sv =====
`include "ir_pulse_width_capture_defines.svh"

module irpwc_fifo #(
    parameter int FIFO_DEPTH = 256,
    parameter int TIME_BITS  = 24,
    parameter int AW         = $clog2(FIFO_DEPTH),
    parameter int CW         = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  irpwc_pkg::fifo_req_t req,
    input  logic [TIME_BITS:0]   word_a,
    input  logic [TIME_BITS:0]   word_b,
    output logic                 pop_hit,
    output logic [TIME_BITS:0]   rdata,
    output logic [CW-1:0]        level,
    output logic                 overflow,
    output logic                 busy
);

    logic [TIME_BITS:0] mem [FIFO_DEPTH];

    logic [AW-1:0]      wr_idx_reg, wr_idx_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg;
    logic [TIME_BITS:0] pend_word_reg;
    logic [TIME_BITS:0] rdata_reg;

    logic               ok_one;
    logic               ok_two;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TIME_BITS:0] mem_wdata;
    logic               mem_re;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        wrap_inc = (a == AW'(FIFO_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign ok_one  = req.push_one && (count_reg < CW'(FIFO_DEPTH));
    assign ok_two  = req.push_two && (count_reg < CW'(FIFO_DEPTH - 1));
    assign pop_hit = req.pop && (count_reg != '0);

    assign rdata    = rdata_reg;
    assign level    = count_reg;
    assign overflow = dropped_reg;
    assign busy     = pend_reg;

    // pointer, fill count and drop flag update
    always_comb
    begin
        wr_idx_next  = wr_idx_reg;
        rd_idx_next  = rd_idx_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        pend_next    = 1'b0;
        if (step)
        begin
            if (req.clear)
            begin
                wr_idx_next  = '0;
                rd_idx_next  = '0;
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                if ((req.push_one && !ok_one) || (req.push_two && !ok_two))
                begin
                    dropped_next = 1'b1;
                end
                if (ok_one)
                begin
                    wr_idx_next = wrap_inc(wr_idx_reg);
                    count_next  = count_reg + 1'b1;
                end
                // second word of a character event goes in the next cycle
                if (ok_two)
                begin
                    wr_idx_next = wrap_inc(wrap_inc(wr_idx_reg));
                    count_next  = count_reg + CW'(2);
                    pend_next   = 1'b1;
                end
                if (pop_hit)
                begin
                    rd_idx_next = wrap_inc(rd_idx_reg);
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            pend_reg    <= pend_next;
        end
    end

    // held second word
    always_ff @(posedge clk)
    begin
        if (step && ok_two)
        begin
            pend_addr_reg <= wrap_inc(wr_idx_reg);
            pend_word_reg <= word_b;
        end
    end

    // single write port shared by first and second word
    assign mem_we    = (step && ok_one && !req.clear) || pend_reg;
    assign mem_waddr = pend_reg ? pend_addr_reg : wr_idx_reg;
    assign mem_wdata = pend_reg ? pend_word_reg : word_a;
    assign mem_re    = step && pop_hit && !req.clear;

    // word memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    `IRPWC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(FIFO_DEPTH))
    `IRPWC_ASSERT_IMPLY(a_no_same_entry, clk, rst_n, mem_we && mem_re, mem_waddr != rd_idx_reg)
    `IRPWC_ASSERT_IMPLY(a_pend_count, clk, rst_n, pend_reg, count_reg >= CW'(2))

endmodule

// ===== tb/ir_pulse_width_capture_test.sv =====
module ir_pulse_width_capture_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = 256;
    localparam int TIME_BITS = 24;
    localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] CHAR_GAP = TIME_BITS'(irpwc_pkg::CHAR_OFFSET);
    localparam logic [TIME_BITS-1:0] TIMEOUT_INIT = TIME_BITS'(irpwc_pkg::TIMEOUT_RESET);
    localparam int LIMIT_NS = 5_000_000;
    localparam int SETTLE_CYCLES = 10;

    // command codes the block treats as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    typedef struct {
        logic [2:0] cmd;
        logic       lvl;
        logic       hold;
    } ir_word_t;

    typedef struct {
        logic                  dv;
        logic [TIME_BITS:0]    word;
        logic [LEVEL_BITS-1:0] level;
        logic                  ovf;
        logic                  sense;
    } capture_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [irpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TIME_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] command = '0;
    logic line_level = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic data_valid;
    logic [TIME_BITS:0] data_word;
    logic [LEVEL_BITS-1:0] fifo_level;
    logic overflow;
    logic sense_now;

    ir_word_t pending_words[$];
    capture_status_t expected_status[$];
    int errors = 0;
    int queued = 0;
    int drive_gap = 0;
    int out_stall = 0;
    logic quiet = 1'b0;
    logic line_now = 1'b0;

    // register copies
    logic                 cfg_mode = 1'b1;
    logic [1:0]           cfg_sense = 2'd2;
    logic [TIME_BITS-1:0] cfg_pulse = '0;
    logic [TIME_BITS-1:0] cfg_timeout = TIMEOUT_INIT;

    // capture state copies
    logic [TIME_BITS-1:0]  us_count = '0;
    logic                  prev_level = 1'b0;
    logic                  active_sense = 1'b0;
    logic [TIME_BITS:0]    fifo_words [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr = '0;
    logic [PTR_BITS-1:0]   rd_ptr = '0;
    logic [LEVEL_BITS-1:0] fifo_fill = '0;
    logic                  lost_word = 1'b0;

    ir_pulse_width_capture #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .line_level(line_level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_valid(data_valid),
        .data_word (data_word),
        .fifo_level(fifo_level),
        .overflow  (overflow),
        .sense_now (sense_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // queue one word, drop it on a full fifo
    function automatic void store_word(input logic [TIME_BITS:0] w);
        if (fifo_fill >= FIFO_DEPTH)
        begin
            lost_word = 1'b1;
        end
        else
        begin
            fifo_words[wr_ptr] = w;
            wr_ptr = wr_ptr + 1'b1;
            fifo_fill = fifo_fill + 1'b1;
        end
    endfunction

    // advance the capture state by one command and return the status it reports
    function automatic capture_status_t next_status(input logic [2:0] cmd, input logic lvl);
        capture_status_t s;
        logic [TIME_BITS-1:0] dur;
        s.dv = 1'b0;
        s.word = '0;
        case (cmd)
            irpwc_pkg::CMD_TICK:
                if (us_count != TIME_MAX)
                    us_count = us_count + 1'b1;
            irpwc_pkg::CMD_SAMPLE:
                if (cfg_mode && lvl != prev_level)
                begin
                    prev_level = lvl;
                    if (us_count > cfg_timeout)
                    begin
                        // a timeout on the active level means the sense was wrong
                        dur = TIME_MAX;
                        if (lvl == active_sense)
                            active_sense = ~active_sense;
                    end
                    else
                    begin
                        dur = us_count;
                    end
                    store_word({lvl == active_sense, dur});
                    us_count = '0;
                end
            irpwc_pkg::CMD_CHAR:
                if (!cfg_mode)
                begin
                    dur = (us_count > CHAR_GAP) ? us_count - CHAR_GAP : '0;
                    store_word({1'b0, dur});
                    store_word({1'b1, cfg_pulse});
                    us_count = '0;
                end
            irpwc_pkg::CMD_READ:
                if (fifo_fill != 0)
                begin
                    s.dv = 1'b1;
                    s.word = fifo_words[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    fifo_fill = fifo_fill - 1'b1;
                end
            irpwc_pkg::CMD_ARM:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                fifo_fill = '0;
                lost_word = 1'b0;
                us_count = '0;
                prev_level = lvl;
                active_sense = cfg_sense[1] ? lvl : cfg_sense[0];
            end
            default:
            begin
            end
        endcase
        s.level = fifo_fill;
        s.ovf = lost_word;
        s.sense = active_sense;
        return s;
    endfunction

    // sender: present queued words with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        logic free;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            line_level <= 1'b0;
            drive_gap <= 0;
        end
        else
        begin
            free = !in_valid || in_ready;
            if (in_valid && in_ready)
                expected_status.push_back(next_status(command, line_level));
            if (free)
            begin
                if (drive_gap > 0)
                begin
                    drive_gap <= drive_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0 &&
                         (!pending_words[0].hold || expected_status.size() == 0))
                begin
                    in_valid <= 1'b1;
                    command <= pending_words[0].cmd;
                    line_level <= pending_words[0].lvl;
                    drive_gap <= quiet ? 0 : $urandom_range(0, 6);
                    void'(pending_words.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compare each status word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_results
        int stall;
        capture_status_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                report("status word with no prediction waiting");
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("data_valid", 32'(data_valid), 32'(want.dv));
                check_field("data_word", 32'(data_word), 32'(want.word));
                check_field("fifo_level", 32'(fifo_level), 32'(want.level));
                check_field("overflow", 32'(overflow), 32'(want.ovf));
                check_field("sense_now", 32'(sense_now), 32'(want.sense));
            end
            stall = quiet ? 0 : $urandom_range(0, 6);
            out_stall <= stall;
            out_ready <= (stall == 0);
        end
        else if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic rare_hold();
        return ($urandom_range(0, 49) == 0);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic add_word(input logic [2:0] cmd, input logic lvl, input logic hold);
        ir_word_t w;
        w.cmd = cmd;
        w.lvl = lvl;
        w.hold = hold;
        pending_words.push_back(w);
        queued++;
        if (cmd == irpwc_pkg::CMD_SAMPLE || cmd == irpwc_pkg::CMD_ARM)
            line_now = lvl;
    endtask

    task automatic put_reg(input irpwc_pkg::cfg_reg_t idx, input logic [TIME_BITS-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // write all four registers back to back, block is idle
    task automatic load_config(input logic m, input logic [1:0] s,
                               input logic [TIME_BITS-1:0] vp,
                               input logic [TIME_BITS-1:0] to);
        cfg_mode = m;
        cfg_sense = s;
        cfg_pulse = vp;
        cfg_timeout = to;
        put_reg(irpwc_pkg::CFG_DEVICE_MODE, {{(TIME_BITS-1){1'b0}}, m});
        put_reg(irpwc_pkg::CFG_SENSE_SETTING, {{(TIME_BITS-2){1'b0}}, s});
        put_reg(irpwc_pkg::CFG_VIRTUAL_PULSE, vp);
        put_reg(irpwc_pkg::CFG_TIMEOUT_US, to);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || expected_status.size() > 0)
            @(posedge clk);
    endtask

    // armed capture with timed events, reads and some noise
    task automatic gen_phase(input int n);
        int start;
        int r;
        int k;
        start = queued;
        add_word(irpwc_pkg::CMD_ARM, rand_bit(), 1'b0);
        while (queued - start < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                add_word(3'($urandom_range(0, 7)), rand_bit(), rare_hold());
            end
            else if (r < 30)
            begin
                repeat ($urandom_range(1, 4))
                    add_word(irpwc_pkg::CMD_READ, rand_bit(), rare_hold());
            end
            else if (r < 33)
            begin
                add_word(irpwc_pkg::CMD_ARM, rand_bit(), rare_hold());
            end
            else
            begin
                // a gap of ticks then the timed event
                if (cfg_mode)
                    k = $urandom_range(0, 12);
                else if ($urandom_range(0, 5) == 0)
                    k = $urandom_range(95, 110);
                else
                    k = $urandom_range(0, 8);
                repeat (k)
                    add_word(irpwc_pkg::CMD_TICK, rand_bit(), rare_hold());
                if (cfg_mode)
                    add_word(irpwc_pkg::CMD_SAMPLE,
                             ($urandom_range(0, 9) == 0) ? line_now : ~line_now,
                             rare_hold());
                else
                    add_word(irpwc_pkg::CMD_CHAR, rand_bit(), rare_hold());
            end
        end
    endtask

    initial
    begin
        logic                 m;
        logic [1:0]           s;
        logic [TIME_BITS-1:0] vp;
        logic [TIME_BITS-1:0] to;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: level mode, sense taken at arm, long timeout
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_ARM, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b1, 1'b1);
        add_word(irpwc_pkg::CMD_CHAR, 1'b0, 1'b0);
        add_word(CMD_SPARE_A, 1'b0, 1'b0);
        add_word(CMD_SPARE_B, 1'b1, 1'b0);
        add_word(CMD_SPARE_C, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        wait_idle();

        // timeout of one, gaps run over it, sense flips on a pulse timeout
        load_config(1'b1, 2'd0, TIME_MAX, TIME_BITS'(1));
        add_word(irpwc_pkg::CMD_ARM, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        wait_idle();

        // zero timeout: only a zero gap escapes it
        load_config(1'b1, 2'd1, '0, '0);
        add_word(irpwc_pkg::CMD_ARM, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_TICK, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        wait_idle();

        // character mode, clamped gap, samples ignored
        load_config(1'b0, 2'd2, TIME_MAX, TIMEOUT_INIT);
        add_word(irpwc_pkg::CMD_ARM, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_CHAR, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_SAMPLE, 1'b1, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        wait_idle();

        // fill the fifo past full, drain some, refill, then arm clears the flag
        quiet = 1'b1;
        load_config(1'b0, 2'd3, TIME_BITS'($urandom), TIME_BITS'($urandom_range(1, 40)));
        add_word(irpwc_pkg::CMD_ARM, 1'b1, 1'b0);
        repeat (140)
        begin
            add_word(irpwc_pkg::CMD_CHAR, rand_bit(), rare_hold());
            if ($urandom_range(0, 9) == 0)
                add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        end
        repeat (12) add_word(irpwc_pkg::CMD_READ, rand_bit(), 1'b0);
        repeat (4) add_word(irpwc_pkg::CMD_CHAR, 1'b0, 1'b0);
        add_word(irpwc_pkg::CMD_ARM, 1'b0, 1'b0);
        repeat (3) add_word(irpwc_pkg::CMD_READ, 1'b0, 1'b0);
        wait_idle();

        // random settings, alternating modes
        for (int p = 0; p < 6; p++)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            m = p[0];
            s = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: vp = '0;
                1: vp = TIME_MAX;
                default: vp = TIME_BITS'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: to = '0;
                1: to = TIME_MAX;
                default: to = TIME_BITS'($urandom_range(1, 40));
            endcase
            load_config(m, s, vp, to);
            gen_phase(80);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_status.size() != 0)
            report($sformatf("%0d predictions never matched", expected_status.size()));
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
